// ===== rtl/acst_pkg.sv =====
package acst_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int FRACTION_BITS  = 16;
    localparam int STAT_WIDTH     = 36;

    localparam int ALLELE_WIDTH   = COUNT_WIDTH + 2;
    localparam int MARGIN_WIDTH   = ALLELE_WIDTH + 1;
    localparam int TOTAL_WIDTH    = ALLELE_WIDTH + 2;
    localparam int PROD_WIDTH     = 2 * ALLELE_WIDTH;
    localparam int HALF_WIDTH     = (PROD_WIDTH + 1) / 2;
    localparam int PAIR_WIDTH     = 2 * MARGIN_WIDTH;
    localparam int PAIR_HALF      = (PAIR_WIDTH + 1) / 2;
    localparam int DEN_WIDTH      = 2 * PAIR_WIDTH;
    localparam int SQ_WIDTH       = 2 * PROD_WIDTH;
    localparam int CHUNK_WIDTH    = (SQ_WIDTH + 2) / 3;
    localparam int NUM_WIDTH      = SQ_WIDTH + TOTAL_WIDTH + FRACTION_BITS;

    localparam int S_DATA_WIDTH   = ((6 * COUNT_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH   = ((STAT_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } ctl_t;

    typedef struct packed {
        logic valid;
        logic degenerate;
        logic saturate;
    } div_ctl_t;

endpackage

// ===== rtl/acst_front.sv =====
module acst_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                enable,
    input  logic                                in_valid,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    case_hom_a1,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    case_het,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    case_hom_a2,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    control_hom_a1,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    control_het,
    input  logic [acst_pkg::COUNT_WIDTH-1:0]    control_hom_a2,
    output acst_pkg::ctl_t                      out_ctl,
    output logic [acst_pkg::NUM_WIDTH-1:0]      out_num,
    output logic [acst_pkg::DEN_WIDTH-1:0]      out_den
);

    localparam int AW = acst_pkg::ALLELE_WIDTH;
    localparam int MW = acst_pkg::MARGIN_WIDTH;
    localparam int TW = acst_pkg::TOTAL_WIDTH;
    localparam int PW = acst_pkg::PROD_WIDTH;
    localparam int HW = acst_pkg::HALF_WIDTH;
    localparam int QW = acst_pkg::PAIR_WIDTH;
    localparam int QH = acst_pkg::PAIR_HALF;
    localparam int DW = acst_pkg::DEN_WIDTH;
    localparam int SW = acst_pkg::SQ_WIDTH;
    localparam int CW = acst_pkg::CHUNK_WIDTH;
    localparam int NW = acst_pkg::NUM_WIDTH;

    acst_pkg::ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg;

    logic [AW-1:0]      a_reg, b_reg, c_reg, d_reg;
    logic [PW-1:0]      ad_reg, bc_reg;
    logic [MW-1:0]      r1_reg, r2_reg, c1_reg, c2_reg;
    logic [TW-1:0]      n2_reg, n3_reg, n4_reg, n5_reg;
    logic [PW-1:0]      diff_reg;
    logic [QW-1:0]      rr_reg, cc_reg;
    logic [2*HW-1:0]    dhh_reg, dhl_reg, dll_reg;
    logic [2*QH-1:0]    phh_reg, phl_reg, plh_reg, pll_reg;
    logic [SW-1:0]      sq_reg;
    logic [DW-1:0]      den5_reg, den6_reg, den7_reg;
    logic [CW+TW-1:0]   m0_reg, m1_reg, m2_reg;
    logic [NW-1:0]      num_reg;

    logic [MW-1:0]      r1_next, r2_next, c1_next, c2_next;
    logic [HW-1:0]      dh, dl;
    logic [QH-1:0]      rh, rl, ch, cl;
    logic [CW-1:0]      k0, k1, k2;

    assign r1_next = MW'(a_reg) + MW'(b_reg);
    assign r2_next = MW'(c_reg) + MW'(d_reg);
    assign c1_next = MW'(a_reg) + MW'(c_reg);
    assign c2_next = MW'(b_reg) + MW'(d_reg);

    assign dh = HW'(diff_reg >> HW);
    assign dl = diff_reg[HW-1:0];
    assign rh = QH'(rr_reg >> QH);
    assign rl = rr_reg[QH-1:0];
    assign ch = QH'(cc_reg >> QH);
    assign cl = cc_reg[QH-1:0];

    assign k0 = CW'(sq_reg);
    assign k1 = CW'(sq_reg >> CW);
    assign k2 = CW'(sq_reg >> (2 * CW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end else if (enable) begin
            ctl1_reg <= '{valid: in_valid, degenerate: 1'b0};
            ctl2_reg <= '{valid: ctl1_reg.valid,
                          degenerate: (r1_next == '0) || (r2_next == '0) ||
                                      (c1_next == '0) || (c2_next == '0)};
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            a_reg    <= AW'({case_hom_a1, 1'b0}) + AW'(case_het);
            b_reg    <= AW'(case_het) + AW'({case_hom_a2, 1'b0});
            c_reg    <= AW'({control_hom_a1, 1'b0}) + AW'(control_het);
            d_reg    <= AW'(control_het) + AW'({control_hom_a2, 1'b0});

            ad_reg   <= a_reg * d_reg;
            bc_reg   <= b_reg * c_reg;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            n2_reg   <= TW'(r1_next) + TW'(r2_next);

            diff_reg <= (ad_reg >= bc_reg) ? ad_reg - bc_reg : bc_reg - ad_reg;
            rr_reg   <= r1_reg * r2_reg;
            cc_reg   <= c1_reg * c2_reg;
            n3_reg   <= n2_reg;

            dhh_reg  <= dh * dh;
            dhl_reg  <= dh * dl;
            dll_reg  <= dl * dl;
            phh_reg  <= rh * ch;
            phl_reg  <= rh * cl;
            plh_reg  <= rl * ch;
            pll_reg  <= rl * cl;
            n4_reg   <= n3_reg;

            sq_reg   <= (SW'(dhh_reg) << (2 * HW)) + (SW'(dhl_reg) << (HW + 1))
                        + SW'(dll_reg);
            den5_reg <= (DW'(phh_reg) << (2 * QH)) + (DW'(phl_reg) << QH)
                        + (DW'(plh_reg) << QH) + DW'(pll_reg);
            n5_reg   <= n4_reg;

            m0_reg   <= k0 * n5_reg;
            m1_reg   <= k1 * n5_reg;
            m2_reg   <= k2 * n5_reg;
            den6_reg <= den5_reg;

            num_reg  <= ((NW'(m2_reg) << (2 * CW)) + (NW'(m1_reg) << CW) + NW'(m0_reg))
                        << acst_pkg::FRACTION_BITS;
            den7_reg <= den6_reg;
        end
    end

    assign out_ctl = ctl7_reg;
    assign out_num = num_reg;
    assign out_den = den7_reg;

endmodule

// ===== rtl/acst_div.sv =====
module acst_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                enable,
    input  acst_pkg::ctl_t                      in_ctl,
    input  logic [acst_pkg::NUM_WIDTH-1:0]      in_num,
    input  logic [acst_pkg::DEN_WIDTH-1:0]      in_den,
    output acst_pkg::div_ctl_t                  out_ctl,
    output logic [acst_pkg::STAT_WIDTH-1:0]     out_quot
);

    localparam int QB = acst_pkg::STAT_WIDTH;
    localparam int NW = acst_pkg::NUM_WIDTH;
    localparam int DW = acst_pkg::DEN_WIDTH;

    acst_pkg::div_ctl_t ctl_reg  [0:QB];
    logic [NW-1:0]      rem_reg  [0:QB];
    logic [DW-1:0]      den_reg  [0:QB];
    logic [QB-1:0]      quot_reg [0:QB];

    logic overflow;

    assign overflow = (in_num >> QB) >= NW'(in_den);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (enable) begin
            ctl_reg[0] <= '{valid: in_ctl.valid, degenerate: in_ctl.degenerate,
                            saturate: overflow};
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quot_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int SHIFT = QB - 1 - k;
        logic          take;
        logic [NW-1:0] rem_next;

        assign take     = (rem_reg[k] >> SHIFT) >= NW'(den_reg[k]);
        assign rem_next = take ? rem_reg[k] - (NW'(den_reg[k]) << SHIFT) : rem_reg[k];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k+1] <= '0;
            end else if (enable) begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (enable) begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_reg[k];
                quot_reg[k+1] <= {quot_reg[k][QB-2:0], take};
            end
        end
    end

    assign out_ctl  = ctl_reg[QB];
    assign out_quot = quot_reg[QB];

    a_nonzero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg[0].valid && !ctl_reg[0].degenerate |-> den_reg[0] != '0)
        else $error("zero denominator on a non-degenerate table");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg[QB].valid && !ctl_reg[QB].degenerate && !ctl_reg[QB].saturate
        |-> rem_reg[QB] < NW'(den_reg[QB]))
        else $error("division remainder not below denominator");

endmodule

// ===== rtl/allelic_chi_square_test.sv =====
// Allelic chi-square test, 2x2 case/control by allele table.
// Slave channel: one transfer carries the six genotype counts of one marker.
// Master channel: one transfer carries the chi-square statistic in unsigned
// fixed point with FRACTION_BITS fraction bits (saturated at the 36-bit maximum)
// in m_tdata, and in m_tuser a flag set when a table margin is zero, in which
// case the statistic is zero.
// Throughput: one marker per cycle while the output is not stalled.
// Pipeline: seven arithmetic stages, one overflow compare stage, one restoring
// division stage per quotient bit (36) and the output register.
// Reset: aresetn, synchronous, empties the pipeline; no results pending after it.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready is low; nothing is lost or repeated. Bubbles drain while the
// output is empty or taken.
module allelic_chi_square_test (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // case_hom_a1, case_het, case_hom_a2, control_hom_a1, control_het, control_hom_a2
    input  logic [acst_pkg::S_DATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // statistic, zero padding
    output logic [acst_pkg::M_DATA_WIDTH-1:0]   m_tdata,
    // degenerate
    output logic [0:0]                          m_tuser
);

    localparam int CW = acst_pkg::COUNT_WIDTH;
    localparam int QB = acst_pkg::STAT_WIDTH;

    logic                                   enable;
    acst_pkg::ctl_t                         front_ctl;
    logic [acst_pkg::NUM_WIDTH-1:0]         front_num;
    logic [acst_pkg::DEN_WIDTH-1:0]         front_den;
    acst_pkg::div_ctl_t                     div_ctl;
    logic [QB-1:0]                          div_quot;

    logic                                   m_tvalid_reg;
    logic [QB-1:0]                          stat_reg;
    logic                                   degen_reg;

    assign enable   = m_tready || !m_tvalid_reg;
    assign s_tready = enable;

    acst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .enable         (enable),
        .in_valid       (s_tvalid),
        .case_hom_a1    (s_tdata[0*CW +: CW]),
        .case_het       (s_tdata[1*CW +: CW]),
        .case_hom_a2    (s_tdata[2*CW +: CW]),
        .control_hom_a1 (s_tdata[3*CW +: CW]),
        .control_het    (s_tdata[4*CW +: CW]),
        .control_hom_a2 (s_tdata[5*CW +: CW]),
        .out_ctl        (front_ctl),
        .out_num        (front_num),
        .out_den        (front_den)
    );

    acst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .in_ctl   (front_ctl),
        .in_num   (front_num),
        .in_den   (front_den),
        .out_ctl  (div_ctl),
        .out_quot (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (enable) begin
            m_tvalid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            degen_reg <= div_ctl.degenerate;
            if (div_ctl.degenerate) begin
                stat_reg <= '0;
            end else if (div_ctl.saturate) begin
                stat_reg <= '1;
            end else begin
                stat_reg <= div_quot;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = acst_pkg::M_DATA_WIDTH'(stat_reg);
    assign m_tuser  = degen_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[QB-1:0] == '0)
        else $error("degenerate result with nonzero statistic");

endmodule
